>>> hdl/atfb_pkg.sv
// Package for the API transmit-request frame builder.
// Holds frame constants, byte-slot indexes and the register bank type.
// No dependencies.
package atfb_pkg;

	localparam int unsigned SLOT_W = 5;

	// Frame constants
	localparam logic [7:0] START_DELIM   = 8'h7E;
	localparam logic [7:0] LEN_OVERHEAD  = 8'd14;
	localparam logic [7:0] FRAME_TYPE_TX = 8'h10;
	localparam logic [7:0] FRAME_ID      = 8'h00;
	localparam logic [7:0] CSUM_BASE     = 8'hFF;

	// Register reset values
	localparam logic [63:0] DEST_LONG_RST  = 64'h0013_A200_4070_1BE8;
	localparam logic [15:0] DEST_SHORT_RST = 16'hFFFE;
	localparam logic [7:0]  RADIUS_RST     = 8'h00;
	localparam logic [7:0]  OPTIONS_RST    = 8'h00;

	// Register indexes
	localparam logic [1:0] REG_DEST_LONG  = 2'd0;
	localparam logic [1:0] REG_DEST_SHORT = 2'd1;
	localparam logic [1:0] REG_RADIUS     = 2'd2;
	localparam logic [1:0] REG_OPTIONS    = 2'd3;

	// Byte slots of one frame; a payload byte inside a frame starts at SLOT_DATA
	localparam logic [SLOT_W-1:0] SLOT_START     = 5'd0;
	localparam logic [SLOT_W-1:0] SLOT_LEN_HI    = 5'd1;
	localparam logic [SLOT_W-1:0] SLOT_LEN_LO    = 5'd2;
	localparam logic [SLOT_W-1:0] SLOT_TYPE      = 5'd3;
	localparam logic [SLOT_W-1:0] SLOT_ID        = 5'd4;
	localparam logic [SLOT_W-1:0] SLOT_LONG_0    = 5'd5;
	localparam logic [SLOT_W-1:0] SLOT_LONG_1    = 5'd6;
	localparam logic [SLOT_W-1:0] SLOT_LONG_2    = 5'd7;
	localparam logic [SLOT_W-1:0] SLOT_LONG_3    = 5'd8;
	localparam logic [SLOT_W-1:0] SLOT_LONG_4    = 5'd9;
	localparam logic [SLOT_W-1:0] SLOT_LONG_5    = 5'd10;
	localparam logic [SLOT_W-1:0] SLOT_LONG_6    = 5'd11;
	localparam logic [SLOT_W-1:0] SLOT_LONG_7    = 5'd12;
	localparam logic [SLOT_W-1:0] SLOT_SHORT_HI  = 5'd13;
	localparam logic [SLOT_W-1:0] SLOT_SHORT_LO  = 5'd14;
	localparam logic [SLOT_W-1:0] SLOT_RADIUS    = 5'd15;
	localparam logic [SLOT_W-1:0] SLOT_OPTIONS   = 5'd16;
	localparam logic [SLOT_W-1:0] SLOT_DATA      = 5'd17;
	localparam logic [SLOT_W-1:0] SLOT_CSUM      = 5'd18;

	typedef struct packed {
		logic [63:0] dest_long;
		logic [15:0] dest_short;
		logic [7:0]  radius;
		logic [7:0]  options;
	} atfb_cfg_t;

endpackage

>>> hdl/atfb_byte_sel.sv
// Byte selector of the frame builder: picks the frame byte for one slot.
// Depends on atfb_pkg.
module atfb_byte_sel import atfb_pkg::*; (
	input  logic [SLOT_W-1:0] slot,
	input  atfb_cfg_t         cfg,
	input  logic [7:0]        plen,
	input  logic [7:0]        data,
	input  logic [7:0]        sum,
	output logic [7:0]        frame_byte,
	output logic              summed
);

	logic [8:0] flen;

	// Length field counts the payload plus the fixed header part after the length
	assign flen = {1'b0, plen} + {1'b0, LEN_OVERHEAD};

	always_comb begin
		frame_byte = 8'h00;
		summed     = 1'b1;
		unique case (slot)
			SLOT_START: begin
				frame_byte = START_DELIM;
				summed     = 1'b0;
			end
			SLOT_LEN_HI: begin
				frame_byte = {7'b0, flen[8]};
				summed     = 1'b0;
			end
			SLOT_LEN_LO: begin
				frame_byte = flen[7:0];
				summed     = 1'b0;
			end
			SLOT_TYPE:     frame_byte = FRAME_TYPE_TX;
			SLOT_ID:       frame_byte = FRAME_ID;
			SLOT_LONG_0:   frame_byte = cfg.dest_long[63:56];
			SLOT_LONG_1:   frame_byte = cfg.dest_long[55:48];
			SLOT_LONG_2:   frame_byte = cfg.dest_long[47:40];
			SLOT_LONG_3:   frame_byte = cfg.dest_long[39:32];
			SLOT_LONG_4:   frame_byte = cfg.dest_long[31:24];
			SLOT_LONG_5:   frame_byte = cfg.dest_long[23:16];
			SLOT_LONG_6:   frame_byte = cfg.dest_long[15:8];
			SLOT_LONG_7:   frame_byte = cfg.dest_long[7:0];
			SLOT_SHORT_HI: frame_byte = cfg.dest_short[15:8];
			SLOT_SHORT_LO: frame_byte = cfg.dest_short[7:0];
			SLOT_RADIUS:   frame_byte = cfg.radius;
			SLOT_OPTIONS:  frame_byte = cfg.options;
			SLOT_DATA:     frame_byte = data;
			SLOT_CSUM: begin
				frame_byte = CSUM_BASE - sum;
				summed     = 1'b0;
			end
			default: begin
				frame_byte = 8'h00;
				summed     = 1'b0;
			end
		endcase
	end

endmodule

>>> hdl/api_transmit_frame_builder.sv
// API transmit-request frame builder, top level. Depends on atfb_pkg, atfb_byte_sel.
// An accepted item is registered in the hold stage, then its bytes pass through the output register.
// Throughput: one output byte per cycle while out_ready is high; the first item of a frame
// emits the full header before its data byte, later items only their data byte, and the
// last item also the checksum byte. The single output byte register sets this rate.
// Reset (arst_n low, asynchronous) clears the frame state and loads register defaults.
module api_transmit_frame_builder import atfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  payload_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        frame_end,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	atfb_cfg_t         cfg_q;

	logic              hold_valid_q;
	logic [7:0]        hold_byte_q;
	logic [7:0]        hold_len_q;
	logic [SLOT_W-1:0] hold_slot_q;
	logic              hold_hdr_q;

	logic              in_frame_q;
	logic [7:0]        remain_q;
	logic [7:0]        sum_q;

	logic              out_valid_q;
	logic [7:0]        frame_byte_q;
	logic              frame_end_q;

	logic              load_out;
	logic              item_last;
	logic              accept;
	logic [7:0]        plen_eff;
	logic [7:0]        remain_d;
	logic              in_frame_d;
	logic [7:0]        sel_byte;
	logic              sel_summed;

	// Register bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_long  <= DEST_LONG_RST;
			cfg_q.dest_short <= DEST_SHORT_RST;
			cfg_q.radius     <= RADIUS_RST;
			cfg_q.options    <= OPTIONS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEST_LONG:  cfg_q.dest_long  <= cfg_wdata;
				REG_DEST_SHORT: cfg_q.dest_short <= cfg_wdata[15:0];
				REG_RADIUS:     cfg_q.radius     <= cfg_wdata[7:0];
				REG_OPTIONS:    cfg_q.options    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Pick the byte for the current slot
	assign plen_eff = (hold_len_q == 8'd0) ? 8'd1 : hold_len_q;

	atfb_byte_sel u_sel (
		.slot       (hold_slot_q),
		.cfg        (cfg_q),
		.plen       (plen_eff),
		.data       (hold_byte_q),
		.sum        (sum_q),
		.frame_byte (sel_byte),
		.summed     (sel_summed)
	);

	// Advance when the output register is free or being drained
	assign load_out  = hold_valid_q && (!out_valid_q || out_ready);
	assign remain_d  = (hold_hdr_q ? plen_eff : remain_q) - 8'd1;
	assign item_last = (hold_slot_q == SLOT_CSUM) ||
		((hold_slot_q == SLOT_DATA) && (remain_d != 8'd0));
	assign in_ready  = !hold_valid_q || (load_out && item_last);
	assign accept    = in_valid && in_ready;

	// Frame state after this cycle
	always_comb begin
		in_frame_d = in_frame_q;
		if (load_out && (hold_slot_q == SLOT_DATA)) begin
			in_frame_d = (remain_d != 8'd0);
		end
	end

	// Hold the accepted item and step through its slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			hold_slot_q  <= SLOT_START;
			hold_hdr_q   <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= 1'b1;
			hold_slot_q  <= in_frame_d ? SLOT_DATA : SLOT_START;
			hold_hdr_q   <= !in_frame_d;
		end else if (load_out && item_last) begin
			hold_valid_q <= 1'b0;
		end else if (load_out) begin
			hold_slot_q  <= hold_slot_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_byte_q <= payload_byte;
			hold_len_q  <= payload_length;
		end
	end

	// Frame state: open flag, bytes left, running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			remain_q   <= 8'd0;
			sum_q      <= 8'd0;
		end else begin
			in_frame_q <= in_frame_d;
			if (load_out) begin
				if (hold_slot_q == SLOT_DATA) begin
					remain_q <= remain_d;
				end
				if (hold_slot_q == SLOT_START || hold_slot_q == SLOT_CSUM) begin
					sum_q <= 8'd0;
				end else if (sel_summed) begin
					sum_q <= sum_q + sel_byte;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			frame_byte_q <= sel_byte;
			frame_end_q  <= (hold_slot_q == SLOT_CSUM);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign frame_end  = frame_end_q;

	// Checks
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> (hold_slot_q <= SLOT_CSUM))
		else $error("slot index past checksum");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!hold_valid_q |-> in_ready)
		else $error("not ready while holding no item");

	a_close_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (hold_slot_q == SLOT_CSUM)) |=> !in_frame_q)
		else $error("frame still open after checksum");

	a_mid_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_frame_d) |=> (hold_slot_q == SLOT_DATA && !hold_hdr_q))
		else $error("item inside a frame did not start at data slot");

endmodule

>>> verif/api_transmit_frame_builder_tb.sv
// Testbench for the API transmit-request frame builder (api_transmit_frame_builder).
// Drives payload items and register writes, predicts every frame byte in a scoreboard
// class and checks the output stream in order. Depends on atfb_pkg and the RTL only.
`timescale 1ns / 1ps

module api_transmit_frame_builder_tb;
	import atfb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [7:0] val;
		logic       last;
	} frame_out_t;

	// Predicts the serialized frame and checks the block's output against it
	class frame_scoreboard;
		atfb_cfg_t  regs;
		bit         in_frame;
		bit [7:0]   remaining;
		bit [7:0]   csum;
		frame_out_t expected_q[$];
		int         mismatches;

		function new();
			regs = '{DEST_LONG_RST, DEST_SHORT_RST, RADIUS_RST, OPTIONS_RST};
			in_frame = 0;
			remaining = 0;
			csum = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] wval);
			case (idx)
				REG_DEST_LONG: regs.dest_long = wval;
				REG_DEST_SHORT: regs.dest_short = wval[15:0];
				REG_RADIUS: regs.radius = wval[7:0];
				REG_OPTIONS: regs.options = wval[7:0];
				default: ;
			endcase
		endfunction

		// Queue one frame byte; summed bytes feed the checksum
		function void push(logic [7:0] bval, bit summed, bit last);
			if (summed)
				csum += bval;
			expected_q.push_back('{bval, last});
		endfunction

		function void note_item(logic [7:0] data, logic [7:0] len);
			bit [7:0]  plen;
			bit [15:0] flen;
			int        k;
			// Open a frame: emit the full header ahead of the first data byte
			if (!in_frame) begin
				plen = (len == 8'd0) ? 8'd1 : len;
				flen = 16'(plen) + 16'(LEN_OVERHEAD);
				csum = 0;
				push(START_DELIM, 0, 0);
				push(flen[15:8], 0, 0);
				push(flen[7:0], 0, 0);
				push(FRAME_TYPE_TX, 1, 0);
				push(FRAME_ID, 1, 0);
				for (k = 7; k >= 0; k--)
					push(regs.dest_long[8*k +: 8], 1, 0);
				push(regs.dest_short[15:8], 1, 0);
				push(regs.dest_short[7:0], 1, 0);
				push(regs.radius, 1, 0);
				push(regs.options, 1, 0);
				in_frame = 1;
				remaining = plen;
			end
			push(data, 1, 0);
			remaining--;
			// Close the frame with the checksum byte
			if (remaining == 8'd0) begin
				push(CSUM_BASE - csum, 0, 1);
				in_frame = 0;
				csum = 0;
			end
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		function void check_result(logic [7:0] got, logic got_end);
			frame_out_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected frame byte %02h end %0b", got, got_end));
				return;
			end
			want = expected_q.pop_front();
			if (got !== want.val || got_end !== want.last)
				flag($sformatf("frame byte %02h end %0b, expected %02h end %0b",
					got, got_end, want.val, want.last));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_length;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_byte;
	logic        frame_end;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	frame_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int hold_req;
	int hold_left;
	int cycle_count;

	api_transmit_frame_builder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.payload_byte(payload_byte),
		.payload_length(payload_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL api_transmit_frame_builder");
			$finish;
		end
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(payload_byte, payload_length);
			if (out_valid && out_ready)
				sb.check_result(frame_byte, frame_end);
		end
	end

	// Drive out_ready: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one item after a random gap; return at the negedge after acceptance
	task automatic send_item(logic [7:0] data, logic [7:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		payload_byte <= data;
		payload_length <= len;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Send a whole frame; lengths on later bytes are noise the block must ignore
	task automatic send_frame(int n);
		int i;
		for (i = 0; i < n; i++)
			send_item(8'($urandom_range(255)), (i == 0) ? 8'(n) : 8'($urandom_range(255)));
	endtask

	task automatic program_regs(logic [63:0] long_v, logic [63:0] short_v,
		logic [63:0] radius_v, logic [63:0] options_v);
		logic [63:0] vals [4];
		int i;
		vals = '{long_v, short_v, radius_v, options_v};
		for (i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_wdata <= vals[i];
			sb.write_reg(2'(i), vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One random phase: mostly short frames, an occasional medium one, optionally led by a 255-byte frame
	task automatic run_phase(int idle_s, int stall_r, int target, bit pressure, bit long_frame);
		int count;
		int len;
		send_idle_pct = idle_s;
		stall_pct = stall_r;
		if (pressure)
			hold_req = HOLD_OFF_CYCLES;
		count = 0;
		if (long_frame) begin
			send_frame(255);
			count = 255;
		end
		while (count < target) begin
			len = ($urandom_range(99) < 8) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			send_frame(len);
			count += len;
		end
		in_valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		payload_byte = 8'd0;
		payload_length = 8'd0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEST_LONG;
		cfg_wdata = 64'd0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		cycle_count = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames with reset register values
		send_item(8'h00, 8'd0);
		send_item(8'hFF, 8'd1);
		send_item(8'hA5, 8'd2);
		send_item(8'h5A, 8'd0);
		send_item(8'h00, 8'd3);
		send_item(8'hFF, 8'd255);
		send_item(8'h80, 8'd1);
		send_item(8'h7F, 8'd1);
		in_valid <= 1'b0;
		wait_drained();

		// Random phases, each under its own register setting
		program_regs(64'd0, 64'd0, 64'd0, 64'd0);
		run_phase(0, 0, 35, 1'b1, 1'b0);
		program_regs('1, '1, '1, '1);
		run_phase(82, 0, 35, 1'b0, 1'b0);
		program_regs({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		run_phase(0, 82, 35, 1'b0, 1'b0);
		program_regs({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		run_phase(34, 34, 35, 1'b0, 1'b1);

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS api_transmit_frame_builder");
		else
			$display("FAIL api_transmit_frame_builder");
		$finish;
	end

endmodule
